// File: design/vmu_pkg.sv
`timescale 1ns / 1ps

package vmu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LANES     = 4;

	// square root: one result bit per stage plus a rounding stage
	localparam int SQ_STEPS = 32;
	localparam int SQ_LAT   = SQ_STEPS + 1;

	// normalize divider: one quotient bit per stage
	localparam int Q_W   = FRAC_BITS + 1;
	localparam int DEN_W = 34;
	localparam int DIV_W = DEN_W + Q_W;

	// s1..s4, square root, divider, output register
	localparam int TOTAL_LAT = 4 + SQ_LAT + Q_W + 1;

	localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

	localparam logic signed [67:0] RND_HALF = 68'sh1 << (FRAC_BITS - 1);
	localparam logic signed [67:0] S32_MAX  = 68'sh7FFF_FFFF;
	localparam logic signed [67:0] S32_MIN  = -68'sh8000_0000;

	localparam logic [DEN_W-1:0] LEN_BIG = DEN_W'(34'h2_0000_0000);
	localparam logic [DEN_W-1:0] LEN_MAX = DEN_W'(34'h0_7FFF_FFFF);

	// cross product operand lanes
	localparam logic [1:0] CR_P1 [LANES] = '{2'd1, 2'd2, 2'd0, 2'd0};
	localparam logic [1:0] CR_P2 [LANES] = '{2'd2, 2'd0, 2'd1, 2'd0};

	typedef enum logic [3:0] {
		FN_ADD   = 4'd0,
		FN_SUB   = 4'd1,
		FN_MULT  = 4'd2,
		FN_SCALE = 4'd3,
		FN_DOT   = 4'd4,
		FN_SQLEN = 4'd5,
		FN_LEN   = 4'd6,
		FN_DIST  = 4'd7,
		FN_NORM  = 4'd8,
		FN_EQUAL = 4'd9,
		FN_CROSS = 4'd10
	} func_t;

	typedef struct packed {
		logic signed [65:0] p1;
		logic signed [63:0] p2;
		logic signed [32:0] sum;
		logic signed [32:0] diff;
		logic [63:0]        sq;
		logic               big;
	} lane_out_t;

	typedef struct packed {
		func_t                   func;
		logic [LANES-1:0]        mask;
		logic                    big;
		logic [LANES-1:0]        neg;
		logic [LANES-1:0][31:0]  mag;
		logic [LANES-1:0][31:0]  res;
		logic [31:0]             scalar;
		logic                    close;
		logic                    sat;
		logic [DEN_W-1:0]        len;
	} pay_t;

	// {clamped, value}
	function automatic logic [32:0] sat32(input logic signed [67:0] v);
		logic [32:0] r;
		if (v > S32_MAX) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < S32_MIN) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

// File: design/vmu_lane.sv
`timescale 1ns / 1ps

module vmu_lane (
	input  logic                clk,
	input  vmu_pkg::func_t      func,
	input  logic signed [31:0]  a,
	input  logic signed [31:0]  b,
	input  logic signed [31:0]  s,
	input  logic signed [31:0]  ca1,
	input  logic signed [31:0]  cb1,
	input  logic signed [31:0]  ca2,
	input  logic signed [31:0]  cb2,
	output vmu_pkg::lane_out_t  lane_o
);

	logic signed [32:0] d, x, y;
	logic signed [65:0] p1;
	logic signed [63:0] p2;
	logic               big;
	vmu_pkg::lane_out_t out_s2;

	always_comb begin
		d = 33'(a) - 33'(b);
		case (func)
			vmu_pkg::FN_MULT, vmu_pkg::FN_DOT: begin
				x = 33'(a);
				y = 33'(b);
			end
			vmu_pkg::FN_SCALE: begin
				x = 33'(a);
				y = 33'(s);
			end
			vmu_pkg::FN_SQLEN, vmu_pkg::FN_LEN, vmu_pkg::FN_NORM: begin
				x = 33'(a);
				y = 33'(a);
			end
			vmu_pkg::FN_DIST, vmu_pkg::FN_EQUAL: begin
				x = d;
				y = d;
			end
			vmu_pkg::FN_CROSS: begin
				x = 33'(ca1);
				y = 33'(cb1);
			end
			default: begin
				x = 33'(a);
				y = 33'(b);
			end
		endcase
		p1  = x * y;
		p2  = ca2 * cb2;
		big = (x > 33'sh0_7FFF_FFFF) || (x < 33'sh1_8000_0001);
	end

	always_ff @(posedge clk) begin
		out_s2.p1   <= p1;
		out_s2.p2   <= p2;
		out_s2.sum  <= 33'(a) + 33'(b);
		out_s2.diff <= d;
		out_s2.sq   <= big ? 64'd0 : p1[63:0];
		out_s2.big  <= big;
	end

	assign lane_o = out_s2;

endmodule

// File: design/vmu_sqrt.sv
`timescale 1ns / 1ps

module vmu_sqrt (
	input  logic        clk,
	input  logic [63:0] rad,
	output logic [32:0] root
);

	localparam int N = vmu_pkg::SQ_STEPS;

	logic [34:0] rem_s  [N];
	logic [31:0] root_s [N];
	logic [63:0] rad_s  [N];
	logic [34:0] rem_i  [N];
	logic [31:0] root_i [N];
	logic [63:0] rad_i  [N];
	logic [34:0] rem_n  [N];
	logic [31:0] root_n [N];
	logic [63:0] rad_n  [N];
	logic [32:0] root_q;

	always_comb begin
		logic [34:0] t;
		logic [34:0] r;
		rem_i[0]  = '0;
		root_i[0] = '0;
		rad_i[0]  = rad;
		for (int k = 1; k < N; k++) begin
			rem_i[k]  = rem_s[k-1];
			root_i[k] = root_s[k-1];
			rad_i[k]  = rad_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			r = {rem_i[k][32:0], rad_i[k][63:62]};
			t = {1'b0, root_i[k], 2'b01};
			if (r >= t) begin
				rem_n[k]  = r - t;
				root_n[k] = {root_i[k][30:0], 1'b1};
			end else begin
				rem_n[k]  = r;
				root_n[k] = {root_i[k][30:0], 1'b0};
			end
			rad_n[k] = rad_i[k] << 2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			rem_s[k]  <= rem_n[k];
			root_s[k] <= root_n[k];
			rad_s[k]  <= rad_n[k];
		end
		root_q <= {1'b0, root_s[N-1]} +
			33'(rem_s[N-1] > {3'b000, root_s[N-1]});
	end

	assign root = root_q;

endmodule

// File: design/vmu_div.sv
`timescale 1ns / 1ps

module vmu_div (
	input  logic                      clk,
	input  logic [vmu_pkg::DIV_W-1:0] num,
	input  logic [vmu_pkg::DEN_W-1:0] den,
	output logic [vmu_pkg::Q_W-1:0]   q
);

	localparam int N = vmu_pkg::Q_W;
	localparam int W = vmu_pkg::DIV_W;

	logic [W-1:0]                    rem_s [N];
	logic [vmu_pkg::DEN_W-1:0]       den_s [N];
	logic [N-1:0]                    q_s   [N];
	logic [W-1:0]                    rem_i [N];
	logic [vmu_pkg::DEN_W-1:0]       den_i [N];
	logic [N-1:0]                    q_i   [N];
	logic [W-1:0]                    rem_n [N];
	logic [N-1:0]                    q_n   [N];

	always_comb begin
		logic [W-1:0] dsh;
		logic         ge;
		rem_i[0] = num;
		den_i[0] = den;
		q_i[0]   = '0;
		for (int k = 1; k < N; k++) begin
			rem_i[k] = rem_s[k-1];
			den_i[k] = den_s[k-1];
			q_i[k]   = q_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			dsh      = W'(den_i[k]) << (N - 1 - k);
			ge       = rem_i[k] >= dsh;
			rem_n[k] = ge ? rem_i[k] - dsh : rem_i[k];
			q_n[k]   = {q_i[k][N-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			rem_s[k] <= rem_n[k];
			den_s[k] <= den_i[k];
			q_s[k]   <= q_n[k];
		end
	end

	assign q = q_s[N-1];

endmodule

// File: design/vector_math_unit_core.sv
`timescale 1ns / 1ps

// channel   signals                                      handshake
// -------   ------------------------------------------   --------------------------
// item in   func dim a_x..a_w b_x..b_w scale             start & !busy
// result    res_x..res_w scalar_res is_close saturated   done, one-cycle strobe
// config    cfg_wdata (equal_threshold)                  cfg_we
//
// One item per cycle, back to back; busy stays low.
// Every func takes the same path through s1..s4, the bit-per-stage square root, the
// normalize divider and the output register.
// arst_n clears the valid pipe and sets equal_threshold to 1.
// The receiver cannot stall; done marks each accepted start as it leaves the valid pipe.

module vector_math_unit_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic               cfg_we,
	input  logic [30:0]        cfg_wdata,
	input  logic [3:0]         func,
	input  logic [2:0]         dim,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] a_w,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] b_w,
	input  logic signed [31:0] scale,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_z,
	output logic signed [31:0] res_w,
	output logic signed [31:0] scalar_res,
	output logic               is_close,
	output logic               saturated
);

	localparam int L   = vmu_pkg::LANES;
	localparam int LAT = vmu_pkg::TOTAL_LAT;

	logic [30:0]           thr_q;
	logic [LAT-1:0]        vld_q;

	logic signed [31:0]    a_in [L];
	logic signed [31:0]    b_in [L];

	vmu_pkg::func_t        fn_s1, fn_s2, fn_s3;
	logic [L-1:0]          mask_s1, mask_s2, mask_s3;
	logic signed [31:0]    a_s1 [L];
	logic signed [31:0]    b_s1 [L];
	logic signed [31:0]    sc_s1;
	logic signed [31:0]    a_s2 [L];
	logic signed [31:0]    a_s3 [L];

	vmu_pkg::lane_out_t    lo [L];

	logic signed [66:0]    v_s3  [L];
	logic signed [67:0]    dp_s3 [2];
	logic [63:0]           sq_s3 [2];
	logic                  big_s3;
	logic [31:0]           ar_s3 [L];
	logic [L-1:0]          as_s3;
	logic [32:0]           as_n  [L];

	vmu_pkg::pay_t         pay_n, pay_s4;
	logic [63:0]           sqs_s4;
	logic [32:0]           sq_len;

	vmu_pkg::pay_t         pd_q [vmu_pkg::SQ_LAT];
	vmu_pkg::pay_t         pj;
	logic [vmu_pkg::DEN_W-1:0] den;
	logic [vmu_pkg::DIV_W-1:0] num [L];
	logic [vmu_pkg::Q_W-1:0]   q   [L];
	vmu_pkg::pay_t         dd_q [vmu_pkg::Q_W];
	vmu_pkg::pay_t         pf, o_n;

	logic [L-1:0][31:0]    res_q;
	logic [31:0]           scalar_q;
	logic                  close_q, sat_q;

	assign a_in[0] = a_x;
	assign a_in[1] = a_y;
	assign a_in[2] = a_z;
	assign a_in[3] = a_w;
	assign b_in[0] = b_x;
	assign b_in[1] = b_y;
	assign b_in[2] = b_z;
	assign b_in[3] = b_w;

	assign busy = 1'b0;
	assign done = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 31'd1;
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	// s1: capture
	always_ff @(posedge clk) begin
		fn_s1   <= vmu_pkg::func_t'(func);
		mask_s1 <= {dim >= 3'd4, dim >= 3'd3, 2'b11};
		sc_s1   <= scale;
		for (int i = 0; i < L; i++) begin
			a_s1[i] <= a_in[i];
			b_s1[i] <= b_in[i];
		end
	end

	// s2: lane products
	for (genvar i = 0; i < L; i++) begin : g_lane
		vmu_lane u_lane (
			.clk    (clk),
			.func   (fn_s1),
			.a      (a_s1[i]),
			.b      (b_s1[i]),
			.s      (sc_s1),
			.ca1    (a_s1[vmu_pkg::CR_P1[i]]),
			.cb1    (b_s1[vmu_pkg::CR_P2[i]]),
			.ca2    (a_s1[vmu_pkg::CR_P2[i]]),
			.cb2    (b_s1[vmu_pkg::CR_P1[i]]),
			.lane_o (lo[i])
		);
	end

	always_ff @(posedge clk) begin
		fn_s2   <= fn_s1;
		mask_s2 <= mask_s1;
		for (int i = 0; i < L; i++) begin
			a_s2[i] <= a_s1[i];
		end
	end

	// s3: cross difference, pair sums, add/sub clamp
	always_comb begin
		for (int i = 0; i < L; i++) begin
			as_n[i] = vmu_pkg::sat32(fn_s2 == vmu_pkg::FN_SUB ?
				68'(lo[i].diff) : 68'(lo[i].sum));
		end
	end

	always_ff @(posedge clk) begin
		fn_s3   <= fn_s2;
		mask_s3 <= mask_s2;
		for (int i = 0; i < L; i++) begin
			a_s3[i]  <= a_s2[i];
			v_s3[i]  <= (fn_s2 == vmu_pkg::FN_CROSS) ?
				67'(lo[i].p1) - 67'(lo[i].p2) : 67'(lo[i].p1);
			ar_s3[i] <= as_n[i][31:0];
			as_s3[i] <= as_n[i][32];
		end
		for (int j = 0; j < 2; j++) begin
			dp_s3[j] <= (mask_s2[2*j] ? 68'(lo[2*j].p1) : 68'sd0) +
				(mask_s2[2*j+1] ? 68'(lo[2*j+1].p1) : 68'sd0);
			sq_s3[j] <= (mask_s2[2*j] ? lo[2*j].sq : 64'd0) +
				(mask_s2[2*j+1] ? lo[2*j+1].sq : 64'd0);
		end
		big_s3 <= |(mask_s2 & {lo[3].big, lo[2].big, lo[1].big, lo[0].big});
	end

	// s4: rounding, clamping, equality
	always_comb begin
		logic [32:0] rv [L];
		logic [32:0] dv;
		logic [63:0] sqsum;
		logic [63:0] lim;
		for (int i = 0; i < L; i++) begin
			rv[i] = vmu_pkg::sat32((68'(v_s3[i]) + vmu_pkg::RND_HALF) >>>
				vmu_pkg::FRAC_BITS);
		end
		dv    = vmu_pkg::sat32((dp_s3[0] + dp_s3[1] + vmu_pkg::RND_HALF) >>>
			vmu_pkg::FRAC_BITS);
		sqsum = sq_s3[0] + sq_s3[1];
		lim   = 64'(thr_q) << vmu_pkg::FRAC_BITS;

		pay_n.func   = fn_s3;
		pay_n.mask   = mask_s3;
		pay_n.big    = big_s3;
		pay_n.res    = '0;
		pay_n.scalar = '0;
		pay_n.close  = 1'b0;
		pay_n.sat    = 1'b0;
		pay_n.len    = '0;
		for (int i = 0; i < L; i++) begin
			pay_n.neg[i] = a_s3[i][31];
			pay_n.mag[i] = a_s3[i][31] ? 32'd0 - 32'(a_s3[i]) : 32'(a_s3[i]);
		end

		case (fn_s3)
			vmu_pkg::FN_ADD, vmu_pkg::FN_SUB: begin
				for (int i = 0; i < L; i++) begin
					if (mask_s3[i]) begin
						pay_n.res[i] = ar_s3[i];
						pay_n.sat    = pay_n.sat | as_s3[i];
					end
				end
			end
			vmu_pkg::FN_MULT, vmu_pkg::FN_SCALE: begin
				for (int i = 0; i < L; i++) begin
					if (mask_s3[i]) begin
						pay_n.res[i] = rv[i][31:0];
						pay_n.sat    = pay_n.sat | rv[i][32];
					end
				end
			end
			vmu_pkg::FN_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					pay_n.res[i] = rv[i][31:0];
					pay_n.sat    = pay_n.sat | rv[i][32];
				end
			end
			vmu_pkg::FN_DOT, vmu_pkg::FN_SQLEN: begin
				pay_n.scalar = dv[31:0];
				pay_n.sat    = dv[32];
			end
			vmu_pkg::FN_EQUAL: begin
				pay_n.close = !big_s3 && (sqsum < lim);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		pay_s4 <= pay_n;
		sqs_s4 <= sq_s3[0] + sq_s3[1];
	end

	vmu_sqrt u_sqrt (
		.clk  (clk),
		.rad  (sqs_s4),
		.root (sq_len)
	);

	always_ff @(posedge clk) begin
		pd_q[0] <= pay_s4;
		for (int k = 1; k < vmu_pkg::SQ_LAT; k++) begin
			pd_q[k] <= pd_q[k-1];
		end
	end

	// length ready: feed the normalize dividers
	always_comb begin
		logic [vmu_pkg::DEN_W-1:0] half;
		pj     = pd_q[vmu_pkg::SQ_LAT-1];
		pj.len = pj.big ? vmu_pkg::LEN_BIG : vmu_pkg::DEN_W'(sq_len);
		den    = pj.len + vmu_pkg::DEN_W'(1);
		half   = den >> 1;
		for (int i = 0; i < L; i++) begin
			num[i] = (vmu_pkg::DIV_W'(pj.mag[i]) << vmu_pkg::FRAC_BITS) +
				vmu_pkg::DIV_W'(half);
		end
	end

	for (genvar i = 0; i < L; i++) begin : g_div
		vmu_div u_div (
			.clk (clk),
			.num (num[i]),
			.den (den),
			.q   (q[i])
		);
	end

	always_ff @(posedge clk) begin
		dd_q[0] <= pj;
		for (int k = 1; k < vmu_pkg::Q_W; k++) begin
			dd_q[k] <= dd_q[k-1];
		end
	end

	always_comb begin
		logic lsat;
		pf   = dd_q[vmu_pkg::Q_W-1];
		o_n  = pf;
		lsat = pf.len > vmu_pkg::LEN_MAX;
		case (pf.func)
			vmu_pkg::FN_LEN, vmu_pkg::FN_DIST: begin
				o_n.scalar = lsat ? 32'h7FFF_FFFF : pf.len[31:0];
				o_n.sat    = lsat;
			end
			vmu_pkg::FN_NORM: begin
				o_n.scalar = lsat ? 32'h7FFF_FFFF : pf.len[31:0];
				o_n.sat    = lsat;
				for (int i = 0; i < L; i++) begin
					if (!pf.mask[i]) begin
						o_n.res[i] = '0;
					end else if (pf.neg[i]) begin
						o_n.res[i] = 32'd0 - 32'(q[i]);
					end else begin
						o_n.res[i] = 32'(q[i]);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		res_q    <= o_n.res;
		scalar_q <= o_n.scalar;
		close_q  <= o_n.close;
		sat_q    <= o_n.sat;
	end

	assign res_x      = res_q[0];
	assign res_y      = res_q[1];
	assign res_z      = res_q[2];
	assign res_w      = res_q[3];
	assign scalar_res = scalar_q;
	assign is_close   = close_q;
	assign saturated  = sat_q;

	a_close_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_close && saturated))
		else $error("equality result with saturation");

	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_close |-> (res_x == 32'sd0 && res_y == 32'sd0 &&
			res_z == 32'sd0 && res_w == 32'sd0 && scalar_res == 32'sd0))
		else $error("equality item carries vector or scalar data");

	// lanes beyond dim divide an unrelated magnitude and are dropped
	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAT-2] && pf.func == vmu_pkg::FN_NORM |->
			(q[0] <= vmu_pkg::Q_ONE && q[1] <= vmu_pkg::Q_ONE &&
			 (!pf.mask[2] || q[2] <= vmu_pkg::Q_ONE) &&
			 (!pf.mask[3] || q[3] <= vmu_pkg::Q_ONE)))
		else $error("normalize quotient above one");

endmodule

// File: bench/vector_math_unit_core_tb.sv
`timescale 1ns / 1ps

module vector_math_unit_core_tb;

	typedef struct packed {
		logic [3:0]        func;
		logic [2:0]        dim;
		logic [3:0][31:0]  a;
		logic [3:0][31:0]  b;
		logic [31:0]       sc;
	} vec_item_t;

	typedef struct packed {
		logic [3:0][31:0]  res;
		logic [31:0]       scalar;
		logic              close;
		logic              sat;
	} vec_res_t;

	localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam logic [67:0] BIG_MARK = 68'h8_0000_0000_0000_0000;
	localparam logic [67:0] WRAP64   = 68'h1_0000_0000_0000_0000;
	localparam logic signed [67:0] HALF = 68'sh1 <<< (vmu_pkg::FRAC_BITS - 1);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cfg_we = 1'b0;
	logic [30:0] cfg_wdata = '0;
	logic [3:0] func = '0;
	logic [2:0] dim = 3'd2;
	logic signed [31:0] a_x = '0, a_y = '0, a_z = '0, a_w = '0;
	logic signed [31:0] b_x = '0, b_y = '0, b_z = '0, b_w = '0;
	logic signed [31:0] scale = '0;
	logic busy, done;
	logic signed [31:0] res_x, res_y, res_z, res_w, scalar_res;
	logic is_close, saturated;

	logic [30:0] eq_limit = 31'd1;
	vec_res_t pending_q[$];
	vec_res_t want;
	int errors = 0;
	int idle_pct = 0;

	always #1 clk = ~clk;

	vector_math_unit_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .func(func), .dim(dim),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w), .scale(scale),
		.res_x(res_x), .res_y(res_y), .res_z(res_z), .res_w(res_w),
		.scalar_res(scalar_res), .is_close(is_close), .saturated(saturated)
	);

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		errors++;
	endtask

	// {clamped, value}
	function automatic logic [32:0] fit32(input logic signed [67:0] v);
		if (v > $signed(68'h7FFF_FFFF)) begin
			return {1'b1, MAXV};
		end else if (v < -$signed(68'h8000_0000)) begin
			return {1'b1, MINV};
		end
		return {1'b0, v[31:0]};
	endfunction

	// exact sum of squares; BIG_MARK when some term reaches 2^31
	function automatic logic [67:0] sum_squares(input vec_item_t it, input bit diff,
			input int n);
		logic signed [67:0] x, m;
		logic [67:0] s;
		s = '0;
		for (int i = 0; i < n; i++) begin
			x = $signed(it.a[i]);
			if (diff) x = x - $signed(it.b[i]);
			m = (x < 0) ? -x : x;
			if (m >= 68'sh8000_0000) return BIG_MARK;
			s = s + m * m;
		end
		return s;
	endfunction

	function automatic logic [67:0] root_nearest(input logic [67:0] sq);
		logic [67:0] s, r, bt;
		if (sq == BIG_MARK) return 68'h2_0000_0000;
		if (sq >= WRAP64) return 68'h1_0000_0000;
		s = sq;
		r = '0;
		bt = 68'h1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (s >= r + bt) begin
				s = s - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		if (s > r) r = r + 1;
		return r;
	endfunction

	function automatic vec_res_t predict_vector_op(input vec_item_t it);
		vec_res_t r;
		logic [32:0] f;
		logic signed [67:0] acc, x, y;
		logic [67:0] len, den, q, m, sq;
		int n;
		int p1[3], p2[3];
		r = '0;
		p1 = '{1, 2, 0};
		p2 = '{2, 0, 1};
		n = (it.dim < 2) ? 2 : (it.dim > 4 ? 4 : int'(it.dim));
		case (it.func)
			vmu_pkg::FN_ADD, vmu_pkg::FN_SUB: begin
				for (int i = 0; i < n; i++) begin
					x = $signed(it.a[i]);
					y = $signed(it.b[i]);
					f = fit32(it.func == vmu_pkg::FN_ADD ? x + y : x - y);
					r.res[i] = f[31:0];
					r.sat |= f[32];
				end
			end
			vmu_pkg::FN_MULT, vmu_pkg::FN_SCALE: begin
				for (int i = 0; i < n; i++) begin
					x = $signed(it.a[i]);
					y = (it.func == vmu_pkg::FN_MULT) ? $signed(it.b[i]) : $signed(it.sc);
					f = fit32((x * y + HALF) >>> vmu_pkg::FRAC_BITS);
					r.res[i] = f[31:0];
					r.sat |= f[32];
				end
			end
			vmu_pkg::FN_DOT, vmu_pkg::FN_SQLEN: begin
				acc = '0;
				for (int i = 0; i < n; i++) begin
					x = $signed(it.a[i]);
					y = (it.func == vmu_pkg::FN_DOT) ? $signed(it.b[i]) : x;
					acc = acc + x * y;
				end
				f = fit32((acc + HALF) >>> vmu_pkg::FRAC_BITS);
				r.scalar = f[31:0];
				r.sat = f[32];
			end
			vmu_pkg::FN_LEN, vmu_pkg::FN_DIST, vmu_pkg::FN_NORM: begin
				len = root_nearest(sum_squares(it, it.func == vmu_pkg::FN_DIST, n));
				f = fit32($signed(len));
				r.scalar = f[31:0];
				r.sat = f[32];
				if (it.func == vmu_pkg::FN_NORM) begin
					den = len + 1;
					for (int i = 0; i < n; i++) begin
						x = $signed(it.a[i]);
						m = (x < 0) ? -x : x;
						q = ((m << vmu_pkg::FRAC_BITS) + den / 2) / den;
						r.res[i] = (x < 0) ? -q[31:0] : q[31:0];
					end
				end
			end
			vmu_pkg::FN_EQUAL: begin
				sq = sum_squares(it, 1'b1, n);
				r.close = (sq < (68'(eq_limit) << vmu_pkg::FRAC_BITS));
			end
			vmu_pkg::FN_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					acc = $signed(it.a[p1[i]]) * $signed(it.b[p2[i]])
						- $signed(it.a[p2[i]]) * $signed(it.b[p1[i]]);
					f = fit32((acc + HALF) >>> vmu_pkg::FRAC_BITS);
					r.res[i] = f[31:0];
					r.sat |= f[32];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		if (done) begin
			if (pending_q.size() == 0) begin
				report("result with no item outstanding");
			end else begin
				want = pending_q.pop_front();
				if ({res_w, res_z, res_y, res_x} != want.res)
					report($sformatf("res got %h %h %h %h exp %h", res_x, res_y, res_z,
						res_w, want.res));
				if (scalar_res != want.scalar)
					report($sformatf("scalar_res got %h exp %h", scalar_res, want.scalar));
				if (is_close != want.close)
					report($sformatf("is_close got %b exp %b", is_close, want.close));
				if (saturated != want.sat)
					report($sformatf("saturated got %b exp %b", saturated, want.sat));
			end
		end
	end

	task automatic send_item(input vec_item_t it);
		func <= it.func;
		dim <= it.dim;
		{a_w, a_z, a_y, a_x} <= it.a;
		{b_w, b_z, b_y, b_x} <= it.b;
		scale <= it.sc;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_q.push_back(predict_vector_op(it));
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (vmu_pkg::TOTAL_LAT + 4) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [30:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		eq_limit = v;
		cfg_we <= 1'b0;
	endtask

	function automatic vec_item_t mk(input logic [3:0] f, input logic [2:0] d,
			input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
			input logic [31:0] aw, input logic [31:0] bx, input logic [31:0] by,
			input logic [31:0] bz, input logic [31:0] bw, input logic [31:0] s);
		vec_item_t it;
		it.func = f;
		it.dim = d;
		it.a = {aw, az, ay, ax};
		it.b = {bw, bz, by, bx};
		it.sc = s;
		return it;
	endfunction

	function automatic logic [31:0] rand_comp;
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh3FFFF);
			3: return 32'($signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh0FF_FFFF);
			4: begin
				case ($urandom_range(0, 4))
					0: return MAXV;
					1: return MINV;
					2: return 32'h0;
					3: return 32'hFFFF_FFFF;
					default: return 32'h0001_0000;
				endcase
			end
			default: return 32'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh1FF_FFFF);
		endcase
	endfunction

	function automatic vec_item_t rand_item(input bit near);
		vec_item_t it;
		it.func = ($urandom_range(99) < 4) ?
			4'($urandom_range(vmu_pkg::FN_CROSS + 1, 15)) :
			4'($urandom_range(vmu_pkg::FN_ADD, vmu_pkg::FN_CROSS));
		it.dim = ($urandom_range(99) < 8) ? 3'($urandom) : 3'($urandom_range(2, 4));
		it.sc = rand_comp();
		for (int i = 0; i < 4; i++) begin
			it.a[i] = rand_comp();
			it.b[i] = rand_comp();
		end
		if (near || (it.func == vmu_pkg::FN_EQUAL && $urandom_range(1))) begin
			if (near) it.func = vmu_pkg::FN_EQUAL;
			for (int i = 0; i < 4; i++)
				it.b[i] = it.a[i] + 32'($signed($urandom_range(0, 1024)) - 512);
		end
		return it;
	endfunction

	task automatic test_directed;
		idle_pct = 0;
		send_item(mk(vmu_pkg::FN_ADD, 4, MAXV, MINV, 1, 32'hFFFF_FFFF, MAXV, MINV,
			2, 5, 0));
		send_item(mk(vmu_pkg::FN_SUB, 4, MINV, MAXV, 0, 7, MAXV, MINV, 0, 3, 0));
		send_item(mk(vmu_pkg::FN_MULT, 4, MAXV, MINV, MINV, 32'h8000, MAXV, MAXV,
			MINV, 1, 0));
		send_item(mk(vmu_pkg::FN_MULT, 3, 32'hFFFF_FFFF, 1, 32'hFFFF_8000, 0,
			32'h8000, 32'h8000, 1, 0, 0));
		send_item(mk(vmu_pkg::FN_SCALE, 2, MINV, 32'h0002_0000, 9, 9, 0, 0, 0, 0,
			MINV));
		send_item(mk(vmu_pkg::FN_DOT, 4, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV,
			MAXV, 0));
		send_item(mk(vmu_pkg::FN_DOT, 2, 32'h0001_0000, 32'h0002_0000, 5, 5,
			32'h0003_0000, 32'hFFFF_0000, 5, 5, 0));
		send_item(mk(vmu_pkg::FN_SQLEN, 4, MINV, MINV, MINV, MINV, 0, 0, 0, 0, 0));
		send_item(mk(vmu_pkg::FN_LEN, 3, 32'h0003_0000, 32'h0004_0000, 0, 99,
			0, 0, 0, 0, 0));
		send_item(mk(vmu_pkg::FN_LEN, 2, MINV, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(vmu_pkg::FN_LEN, 4, MAXV, MAXV, MAXV, MAXV, 0, 0, 0, 0, 0));
		send_item(mk(vmu_pkg::FN_DIST, 2, MAXV, 0, 0, 0, MINV, 0, 0, 0, 0));
		send_item(mk(vmu_pkg::FN_DIST, 4, 32'h0001_0000, 0, 0, 0, 0, 0, 0,
			32'h0001_0000, 0));
		send_item(mk(vmu_pkg::FN_NORM, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(vmu_pkg::FN_NORM, 3, MINV, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
		send_item(mk(vmu_pkg::FN_NORM, 2, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(vmu_pkg::FN_NORM, 4, 32'hFFFD_0000, 32'h0004_0000, 0, 0,
			0, 0, 0, 0, 0));
		send_item(mk(vmu_pkg::FN_EQUAL, 4, 5, 6, 7, 8, 5, 6, 7, 8, 0));
		send_item(mk(vmu_pkg::FN_EQUAL, 2, MAXV, 0, 0, 0, MINV, 0, 0, 0, 0));
		send_item(mk(vmu_pkg::FN_CROSS, 2, 32'h0001_0000, 0, 0, 7, 0, 32'h0001_0000,
			0, 7, 0));
		send_item(mk(vmu_pkg::FN_CROSS, 4, MAXV, MINV, MAXV, 1, MINV, MAXV, MINV,
			1, 0));
		send_item(mk(vmu_pkg::FN_ADD, 0, 1, 2, 3, 4, 1, 2, 3, 4, 0));
		send_item(mk(vmu_pkg::FN_SUB, 7, 1, 2, 3, 4, 4, 3, 2, 1, 0));
		send_item(mk(4'd11, 4, 1, 2, 3, 4, 5, 6, 7, 8, 9));
		send_item(mk(4'd15, 3, MAXV, MAXV, 1, 1, MINV, 1, 1, 1, MAXV));
	endtask

	task automatic test_threshold;
		logic [30:0] vals[5];
		vals = '{31'd0, 31'h7FFF_FFFF, 31'd100, 31'($urandom), 31'd1};
		idle_pct = 20;
		foreach (vals[k]) begin
			set_threshold(vals[k]);
			repeat (25) send_item(rand_item(1'b1));
		end
	endtask

	task automatic test_random(input int pct, input int count);
		idle_pct = pct;
		repeat (count) send_item(rand_item(1'b0));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold();
		set_threshold(31'($urandom_range(1, 32'h7FFF)));
		test_random(0, 260);
		test_random(64, 260);
		test_random(20, 260);
		drain();
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
design/vmu_pkg.sv
design/vmu_lane.sv
design/vmu_sqrt.sv
design/vmu_div.sv
design/vector_math_unit_core.sv
bench/vector_math_unit_core_tb.sv
